>>> hdl/ipa_pkg.sv
// ============================================================================
// ID pool allocator package
// Sizes, payload structs, command and status codes and the find-first helpers
// shared by the ID pool allocator.
// ============================================================================
package ipa_pkg;

  localparam int ID_W      = 64;
  localparam int POOL_SIZE = 1024;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int ROWS      = (POOL_SIZE + WORD_W - 1) / WORD_W;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int OFF_W     = ROW_W + BIT_W;
  localparam int CUR_W     = OFF_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [ID_W-1:0]  SIGN_BIT    = {1'b1, {(ID_W-1){1'b0}}};
  localparam logic [ID_W-1:0]  SPAN_MAX_ID = ID_W'(POOL_SIZE - 1);
  localparam logic [OFF_W-1:0] SPAN_MAX    = OFF_W'(POOL_SIZE - 1);

  localparam logic [1:0] CMD_GEN  = 2'd0;
  localparam logic [1:0] CMD_FREE = 2'd1;
  localparam logic [1:0] CMD_DECL = 2'd2;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_EXH  = 2'd1;
  localparam logic [1:0] STAT_IGN  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV = 2'd2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [CUR_W-1:0]  cur_t;

  typedef struct packed {
    logic [1:0]             cmd;
    logic signed [ID_W-1:0] id;
  } in_item_t;

  typedef struct packed {
    logic signed [ID_W-1:0] result_id;
    logic [1:0]             status;
  } out_item_t;

  // Lowest set row flag: {found, index}.
  function automatic logic [ROW_W:0] ff_rows(input logic [ROWS-1:0] v);
    logic       found;
    logic [ROW_W-1:0] idx;
    found = 1'b0;
    idx   = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (v[i]) begin
        found = 1'b1;
        idx   = ROW_W'(i);
      end
    end
    return {found, idx};
  endfunction

  // Lowest set bit of a bitmap word: {found, index}.
  function automatic logic [BIT_W:0] ff_word(input word_t v);
    logic       found;
    logic [BIT_W-1:0] idx;
    found = 1'b0;
    idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        found = 1'b1;
        idx   = BIT_W'(i);
      end
    end
    return {found, idx};
  endfunction

endpackage

>>> hdl/id_pool_allocator.sv
// ============================================================================
// ID pool allocator
// Hands out IDs from a configured range and tracks used and freed IDs.
// ============================================================================
// Usage: requests arrive as transfers on the in_ channel (cmd, id) and every
// request produces exactly one result transfer on the out_ channel
// (result_id, status). Generate returns the smallest freed ID, or else the
// next unused ID from the cursor; free and declare echo the ID given.
// Registers id_min, id_max and id_invalid are written on the cfg_ channel,
// only while the block is idle; each write re-runs pool setup (order,
// span, fix and invalid steps). A cursor generate reads 32-bit bitmap rows
// from the cursor row on, one row read per cycle from the used bitmap RAM.
// One request is in flight at a time; a new one is taken once the previous
// result sits in the output register. Reset runs the same setup with the
// reset register values; the bitmaps need no clearing pass because each
// row carries a valid flag. If the receiver stalls, the result waits in the
// output register and the next result waits in the sequencer until the
// register empties.
// ============================================================================
module id_pool_allocator (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  ipa_pkg::in_item_t                      in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output ipa_pkg::out_item_t                     out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ipa_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ipa_pkg::ID_W-1:0]               cfg_data
);
  import ipa_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_SET_ORD   = 11'b000_0000_0010,
    ST_SET_SPAN  = 11'b000_0000_0100,
    ST_SET_FIX   = 11'b000_0000_1000,
    ST_SET_INV   = 11'b000_0001_0000,
    ST_OFFS      = 11'b000_0010_0000,
    ST_MOD       = 11'b000_0100_0000,
    ST_GEN_FREED = 11'b000_1000_0000,
    ST_GEN_SCAN  = 11'b001_0000_0000,
    ST_MKID      = 11'b010_0000_0000,
    ST_EMIT      = 11'b100_0000_0000
  } state_t;

  // Control registers.
  state_t           state_r, state_nxt;
  logic [ID_W-1:0]  min_r, min_nxt;
  logic [ID_W-1:0]  max_r, max_nxt;
  logic [ID_W-1:0]  inv_r, inv_nxt;
  cur_t             cur_r, cur_nxt;
  logic [ROWS-1:0]  used_vld_r, used_vld_nxt;
  logic [ROWS-1:0]  freed_vld_r, freed_vld_nxt;
  logic [ROWS-1:0]  freed_any_r, freed_any_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [ID_W-1:0]  lo_r, lo_nxt;
  logic [ID_W-1:0]  hi_r, hi_nxt;
  off_t             span_r, span_nxt;
  logic             fix_r, fix_nxt;
  logic             inv_in_r, inv_in_nxt;
  off_t             inv_off_r, inv_off_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  off_t             off_r, off_nxt;
  logic             inr_r, inr_nxt;
  row_t             row_r, row_nxt;
  logic [ID_W-1:0]  res_id_r, res_id_nxt;
  logic [1:0]       res_st_r, res_st_nxt;
  out_item_t        out_data_r, out_data_nxt;

  // Shared 64-bit adder/subtractor, used for the wide sums, differences and the bound ordering compare.
  logic [ID_W-1:0]  alu_a, alu_b;
  logic             alu_sub;
  logic [ID_W:0]    alu_sum;
  logic [ID_W-1:0]  alu_diff;
  logic             alu_borrow;
  logic             alu_inr;

  // Bitmap RAM interface; both maps are read and written together.
  logic             rd_en, wr_en;
  row_t             rd_row;
  word_t            used_rd, freed_rd;
  word_t            used_wdata, freed_wdata;
  word_t            used_eff, freed_eff;

  logic             in_acc, cfg_acc;
  logic [ROW_W:0]   fr_res;
  logic [BIT_W:0]   fw_res, su_res;
  word_t            blk;
  word_t            bmask;
  row_t             cur_row, span_row;
  logic             is_inv_off;

  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ipa_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_used_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (row_r),
    .wr_data (used_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_row),
    .rd_data (used_rd)
  );

  ipa_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_freed_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (row_r),
    .wr_data (freed_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_row),
    .rd_data (freed_rd)
  );

  // A row that has never been written since setup reads as all clear.
  assign used_eff  = used_vld_r[row_r]  ? used_rd  : '0;
  assign freed_eff = freed_vld_r[row_r] ? freed_rd : '0;

  // Operand selection for the shared unit.
  always_comb begin
    alu_a   = lo_r ^ SIGN_BIT;
    alu_b   = ID_W'(off_r);
    alu_sub = 1'b0;
    case (state_r)
      ST_SET_ORD: begin
        alu_a   = min_r ^ SIGN_BIT;
        alu_b   = max_r ^ SIGN_BIT;
        alu_sub = 1'b1;
      end
      ST_SET_SPAN: begin
        alu_a   = hi_r;
        alu_b   = lo_r;
        alu_sub = 1'b1;
      end
      ST_SET_FIX: begin
        alu_a   = hi_r;
        alu_b   = ID_W'(1);
        alu_sub = 1'b1;
      end
      ST_SET_INV: begin
        alu_a   = inv_r ^ SIGN_BIT;
        alu_b   = lo_r;
        alu_sub = 1'b1;
      end
      ST_OFFS: begin
        alu_a   = id_r ^ SIGN_BIT;
        alu_b   = lo_r;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = lo_r ^ SIGN_BIT;
        alu_b   = ID_W'(off_r);
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum    = {1'b0, alu_a} + {1'b0, alu_b ^ {ID_W{alu_sub}}}
                    + {{ID_W{1'b0}}, alu_sub};
  assign alu_diff   = alu_sum[ID_W-1:0];
  assign alu_borrow = alu_sub & ~alu_sum[ID_W];
  // Difference lands inside the pool span: the operand is a pool member.
  assign alu_inr    = !alu_borrow && (alu_diff[ID_W-1:OFF_W] == '0)
                    && (alu_diff[OFF_W-1:0] <= span_r);

  assign fr_res   = ff_rows(freed_any_r);
  assign fw_res   = ff_word(freed_eff);
  assign cur_row  = cur_r[OFF_W-1:BIT_W];
  assign span_row = span_r[OFF_W-1:BIT_W];
  assign bmask    = word_t'(1) << off_r[BIT_W-1:0];
  assign is_inv_off = inv_in_r && (off_r == inv_off_r);

  // Blocked positions in the row under the cursor scan: used, the invalid
  // ID, positions below the cursor and positions beyond the pool span.
  always_comb begin
    off_t pos;
    pos = '0;
    for (int i = 0; i < WORD_W; i++) begin
      pos    = {row_r, BIT_W'(i)};
      blk[i] = used_eff[i] || (BIT_W'(i) < cur_r[BIT_W-1:0]) || (pos > span_r)
            || (inv_in_r && (pos == inv_off_r));
    end
  end

  assign su_res = ff_word(~blk);

  always_comb begin
    state_nxt     = state_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    inv_nxt       = inv_r;
    cur_nxt       = cur_r;
    used_vld_nxt  = used_vld_r;
    freed_vld_nxt = freed_vld_r;
    freed_any_nxt = freed_any_r;
    out_valid_nxt = out_valid_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    span_nxt      = span_r;
    fix_nxt       = fix_r;
    inv_in_nxt    = inv_in_r;
    inv_off_nxt   = inv_off_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    off_nxt       = off_r;
    inr_nxt       = inr_r;
    row_nxt       = row_r;
    res_id_nxt    = res_id_r;
    res_st_nxt    = res_st_r;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_row        = row_r;
    wr_en         = 1'b0;
    used_wdata    = used_eff;
    freed_wdata   = freed_eff;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          case (cfg_index)
            REG_MIN: begin
              min_nxt   = cfg_data;
              state_nxt = ST_SET_ORD;
            end
            REG_MAX: begin
              max_nxt   = cfg_data;
              state_nxt = ST_SET_ORD;
            end
            REG_INV: begin
              inv_nxt   = cfg_data;
              state_nxt = ST_SET_ORD;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end else if (in_acc) begin
          cmd_nxt    = in_data.cmd;
          id_nxt     = in_data.id;
          res_id_nxt = in_data.id;
          res_st_nxt = STAT_IGN;
          case (in_data.cmd)
            CMD_GEN: begin
              if (fr_res[ROW_W]) begin
                rd_en     = 1'b1;
                rd_row    = fr_res[ROW_W-1:0];
                row_nxt   = fr_res[ROW_W-1:0];
                state_nxt = ST_GEN_FREED;
              end else if (cur_r > {1'b0, span_r}) begin
                res_id_nxt = inv_r;
                res_st_nxt = STAT_EXH;
                state_nxt  = ST_EMIT;
              end else begin
                rd_en     = 1'b1;
                rd_row    = cur_row;
                row_nxt   = cur_row;
                state_nxt = ST_GEN_SCAN;
              end
            end
            CMD_FREE, CMD_DECL: begin
              state_nxt = ST_OFFS;
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      // Pool setup: order the bounds, measure the span, fix equal bounds,
      // then place the invalid ID and the cursor, and mark every row unwritten.
      ST_SET_ORD: begin
        lo_nxt    = alu_borrow ? alu_a : alu_b;
        hi_nxt    = alu_borrow ? alu_b : alu_a;
        state_nxt = ST_SET_SPAN;
      end
      ST_SET_SPAN: begin
        if (alu_diff == '0) begin
          span_nxt = OFF_W'(1);
        end else if (alu_diff > SPAN_MAX_ID) begin
          span_nxt = SPAN_MAX;
        end else begin
          span_nxt = alu_diff[OFF_W-1:0];
        end
        fix_nxt   = (alu_diff == '0) && (&hi_r);
        state_nxt = ST_SET_FIX;
      end
      ST_SET_FIX: begin
        // Equal bounds at the very top: the low end moves down instead.
        if (fix_r) begin
          lo_nxt = alu_diff;
        end
        state_nxt = ST_SET_INV;
      end
      ST_SET_INV: begin
        inv_in_nxt    = alu_inr;
        inv_off_nxt   = alu_diff[OFF_W-1:0];
        cur_nxt       = (alu_inr && (alu_diff[OFF_W-1:0] == '0)) ? CUR_W'(1) : '0;
        used_vld_nxt  = '0;
        freed_vld_nxt = '0;
        freed_any_nxt = '0;
        state_nxt     = ST_IDLE;
      end

      ST_OFFS: begin
        off_nxt   = alu_diff[OFF_W-1:0];
        inr_nxt   = alu_inr;
        rd_en     = 1'b1;
        rd_row    = alu_diff[OFF_W-1:BIT_W];
        row_nxt   = alu_diff[OFF_W-1:BIT_W];
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (inr_r) begin
          if (cmd_r == CMD_FREE) begin
            if ((used_eff & bmask) != '0) begin
              used_wdata  = used_eff & ~bmask;
              freed_wdata = freed_eff | bmask;
              wr_en       = 1'b1;
              res_st_nxt  = STAT_DONE;
            end
          end else begin
            if ((freed_eff & bmask) != '0) begin
              used_wdata  = used_eff | bmask;
              freed_wdata = freed_eff & ~bmask;
              wr_en       = 1'b1;
              res_st_nxt  = STAT_DONE;
            end else if (!is_inv_off) begin
              used_wdata  = used_eff | bmask;
              wr_en       = 1'b1;
              res_st_nxt  = STAT_DONE;
            end
          end
        end
        state_nxt = ST_EMIT;
      end

      ST_GEN_FREED: begin
        off_nxt     = {row_r, fw_res[BIT_W-1:0]};
        used_wdata  = used_eff | (word_t'(1) << fw_res[BIT_W-1:0]);
        freed_wdata = freed_eff & ~(word_t'(1) << fw_res[BIT_W-1:0]);
        wr_en       = 1'b1;
        state_nxt   = ST_MKID;
      end
      ST_GEN_SCAN: begin
        if (su_res[BIT_W]) begin
          off_nxt    = {row_r, su_res[BIT_W-1:0]};
          used_wdata = used_eff | (word_t'(1) << su_res[BIT_W-1:0]);
          wr_en      = 1'b1;
          cur_nxt    = CUR_W'({row_r, su_res[BIT_W-1:0]}) + CUR_W'(1);
          state_nxt  = ST_MKID;
        end else if (row_r == span_row) begin
          cur_nxt    = CUR_W'(span_r) + CUR_W'(1);
          res_id_nxt = inv_r;
          res_st_nxt = STAT_EXH;
          state_nxt  = ST_EMIT;
        end else begin
          cur_nxt = CUR_W'({row_r + ROW_W'(1), {BIT_W{1'b0}}});
          rd_en   = 1'b1;
          rd_row  = row_r + ROW_W'(1);
          row_nxt = row_r + ROW_W'(1);
        end
      end
      ST_MKID: begin
        res_id_nxt = alu_diff;
        res_st_nxt = STAT_DONE;
        state_nxt  = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.result_id = res_id_r;
          out_data_nxt.status    = res_st_r;
          state_nxt              = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Any row write makes both maps of that row valid.
    if (wr_en) begin
      used_vld_nxt[row_r]  = 1'b1;
      freed_vld_nxt[row_r] = 1'b1;
      freed_any_nxt[row_r] = |freed_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SET_ORD;
      min_r       <= '0;
      max_r       <= ID_W'(1023);
      inv_r       <= '1;
      cur_r       <= '0;
      used_vld_r  <= '0;
      freed_vld_r <= '0;
      freed_any_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      inv_r       <= inv_nxt;
      cur_r       <= cur_nxt;
      used_vld_r  <= used_vld_nxt;
      freed_vld_r <= freed_vld_nxt;
      freed_any_r <= freed_any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    span_r     <= span_nxt;
    fix_r      <= fix_nxt;
    inv_in_r   <= inv_in_nxt;
    inv_off_r  <= inv_off_nxt;
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    off_r      <= off_nxt;
    inr_r      <= inr_nxt;
    row_r      <= row_nxt;
    res_id_r   <= res_id_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  // The cursor never runs more than one step past the pool span.
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cur_r <= CUR_W'(span_r) + CUR_W'(1)))
    else $error("cursor beyond pool span");

  // A row flagged as holding freed IDs must have been written since setup.
  a_freed_any_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (freed_any_r & ~freed_vld_r) == '0)
    else $error("freed summary set on an unwritten row");

  // The row chosen from the freed summary really holds a freed ID.
  a_freed_row_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN_FREED) |-> fw_res[BIT_W])
    else $error("freed summary row holds no freed ID");

  // Exhaustion is always reported with the invalid ID.
  a_exh_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == STAT_EXH))
      |-> (out_data_r.result_id == inv_r))
    else $error("exhausted result without invalid ID");

  // Writing a defined register always re-runs setup.
  a_cfg_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_acc && ((cfg_index == REG_MIN) || (cfg_index == REG_MAX)
                 || (cfg_index == REG_INV))) |=> (state_r == ST_SET_ORD))
    else $error("register write did not start setup");

endmodule

>>> hdl/ipa_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ============================================================================
module ipa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> tb/id_pool_allocator_tb.sv
// ============================================================================
// ID pool allocator testbench
// Requests go in as transfers on the in_ channel and results come back on the
// out_ channel. A behavioural copy of the pool inside this bench works out
// each result and checks it field by field. A short directed table runs
// first. Random phases follow, each on its own pool setting, with both
// channels idling at random in all but the last two phases.
// ============================================================================
module id_pool_allocator_tb;
  import ipa_pkg::*;

  // Codes that the package leaves unnamed: the spare register index and the
  // unused command value.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
  localparam logic [1:0]           CMD_UNKNOWN = 2'd3;

  localparam logic [ID_W-1:0] ID_TOP    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ID_W-1:0] ID_BOTTOM = 64'h8000_0000_0000_0000;
  localparam logic [ID_W-1:0] ID_NEG1   = '1;

  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 175;

  // Pool settings {id_min, id_max, id_invalid} for the random phases. They cover a
  // small pool with the invalid ID in the middle, equal bounds, reversed
  // bounds, the full 64-bit range that saturates, the top of the range, a
  // saturated pool with the invalid ID at its new high end and a plain pool.
  // Phase 6 draws its own random setting.
  localparam logic [ID_W-1:0] PHASE_CFG [PHASES][3] = '{
    '{-64'sd10,      64'sd20,   64'sd0},
    '{64'sd100,      64'sd100,  64'sd101},
    '{64'sd50,       -64'sd50,  64'sd7777},
    '{ID_BOTTOM,     ID_TOP,    ID_BOTTOM},
    '{ID_TOP - 64'd3, ID_TOP,   ID_TOP},
    '{-64'sd1000,    64'sd1000, 64'sd23},
    '{64'sd0,        64'sd0,    64'sd0},
    '{64'sd0,        64'sd15,   ID_NEG1}
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ID_W-1:0]      cfg_data  = '0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  id_pool_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Behavioural pool. The registers are kept as written; the effective pool
  // is held with its low end biased (sign bit flipped) so that plain unsigned
  // compares follow signed order.
  // --------------------------------------------------------------------------
  logic [ID_W-1:0] reg_lo, reg_hi, reg_inv;
  logic [ID_W-1:0] pool_base;
  int              pool_span;
  int              inv_off;
  int              cursor_off;
  bit              inv_in_pool;
  bit              used_bits  [POOL_SIZE];
  bit              freed_bits [POOL_SIZE];

  out_item_t       pending_results [$];
  logic [ID_W-1:0] held_ids [$];
  int              fail_count = 0;
  int              send_idle;
  int              recv_idle;

  // Setup as the block runs it after every register write: order the
  // bounds, widen equal bounds (downwards when they sit at the very top),
  // clamp to the pool size, clear both bitmaps and step the cursor past an
  // invalid ID that sits at the low end.
  function automatic void rebuild_pool();
    logic [ID_W-1:0] a, b, inv_b, lo, hi;
    a     = reg_lo ^ SIGN_BIT;
    b     = reg_hi ^ SIGN_BIT;
    inv_b = reg_inv ^ SIGN_BIT;
    if (a > b) begin
      lo = b;
      hi = a;
    end else begin
      lo = a;
      hi = b;
    end
    if (lo == hi) begin
      if (hi == '1) lo = hi - 64'd1;
      else hi = lo + 64'd1;
    end
    if (hi - lo > SPAN_MAX_ID) hi = lo + SPAN_MAX_ID;
    pool_base   = lo;
    pool_span   = int'(hi - lo);
    inv_in_pool = (inv_b >= lo) && (inv_b <= hi);
    inv_off     = inv_in_pool ? int'(inv_b - lo) : 0;
    foreach (used_bits[i]) begin
      used_bits[i]  = 1'b0;
      freed_bits[i] = 1'b0;
    end
    cursor_off = (inv_in_pool && inv_off == 0) ? 1 : 0;
  endfunction

  // A write to the spare index changes nothing and does not re-run setup.
  function automatic void write_pool_reg(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] val);
    case (idx)
      REG_MIN: reg_lo  = val;
      REG_MAX: reg_hi  = val;
      REG_INV: reg_inv = val;
      default: return;
    endcase
    rebuild_pool();
  endfunction

  function automatic logic [ID_W-1:0] id_at(logic [ID_W-1:0] off);
    return (pool_base ^ SIGN_BIT) + off;
  endfunction

  function automatic bit is_reserved(int off);
    return inv_in_pool && off == inv_off;
  endfunction

  function automatic bit pool_offset(logic [ID_W-1:0] id, output int off);
    logic [ID_W-1:0] b;
    off = 0;
    b   = id ^ SIGN_BIT;
    if (b < pool_base || (b - pool_base) > 64'(pool_span)) return 1'b0;
    off = int'(b - pool_base);
    return 1'b1;
  endfunction

  // Works out the result of one request and updates the pool state.
  function automatic out_item_t predict_pool_result(in_item_t req);
    out_item_t res;
    int        c, off;
    bit        found;
    res.result_id = req.id;
    res.status    = STAT_IGN;
    found = 1'b0;
    c     = 0;
    off   = 0;
    case (req.cmd)
      CMD_GEN: begin
        // The smallest freed ID wins over the cursor.
        for (int i = 0; i <= pool_span && !found; i++) begin
          if (freed_bits[i]) begin
            found = 1'b1;
            c     = i;
          end
        end
        if (found) begin
          freed_bits[c] = 1'b0;
          used_bits[c]  = 1'b1;
          res.result_id = id_at(64'(c));
          res.status    = STAT_DONE;
        end else begin
          c = cursor_off;
          while (c <= pool_span && (used_bits[c] || is_reserved(c))) c++;
          if (c > pool_span) begin
            // Exhausted: only the cursor moves, to just past the high end.
            cursor_off    = c;
            res.result_id = reg_inv;
            res.status    = STAT_EXH;
          end else begin
            used_bits[c]  = 1'b1;
            res.result_id = id_at(64'(c));
            res.status    = STAT_DONE;
            c++;
            if (is_reserved(c)) c++;
            cursor_off = c;
          end
        end
      end
      CMD_FREE: begin
        if (pool_offset(req.id, off)) begin
          if (used_bits[off]) begin
            used_bits[off]  = 1'b0;
            freed_bits[off] = 1'b1;
            res.status      = STAT_DONE;
          end
        end
      end
      CMD_DECL: begin
        // A freed ID may be declared even if it is the invalid one.
        if (pool_offset(req.id, off)) begin
          if (freed_bits[off]) begin
            freed_bits[off] = 1'b0;
            used_bits[off]  = 1'b1;
            res.status      = STAT_DONE;
          end else if (!is_reserved(off)) begin
            used_bits[off] = 1'b1;
            res.status     = STAT_DONE;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table. Rows with a typed result are checked against that value;
  // plain request rows are checked against the behavioural pool.
  // --------------------------------------------------------------------------
  typedef enum logic [1:0] {ROW_REQ, ROW_CHK, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    logic [1:0]      code;
    logic [ID_W-1:0] val;
    logic [ID_W-1:0] want_id;
    logic [1:0]      want_st;
  } dir_row_t;

  function automatic dir_row_t reg_row(logic [1:0] idx, logic [ID_W-1:0] val);
    return '{kind: ROW_REG, code: idx, val: val, want_id: '0, want_st: '0};
  endfunction

  function automatic dir_row_t req_row(logic [1:0] cmd, logic [ID_W-1:0] id);
    return '{kind: ROW_REQ, code: cmd, val: id, want_id: '0, want_st: '0};
  endfunction

  function automatic dir_row_t chk_row(logic [1:0] cmd, logic [ID_W-1:0] id,
                                       logic [ID_W-1:0] want_id, logic [1:0] want_st);
    return '{kind: ROW_CHK, code: cmd, val: id, want_id: want_id, want_st: want_st};
  endfunction

  dir_row_t directed_tbl [30] = '{
    // Reset pool 0..1023 with the invalid ID -1 outside it.
    chk_row(CMD_GEN,     64'd0,     64'd0,     STAT_DONE),
    chk_row(CMD_GEN,     ID_NEG1,   64'd1,     STAT_DONE),
    chk_row(CMD_FREE,    64'd0,     64'd0,     STAT_DONE),
    chk_row(CMD_GEN,     ID_TOP,    64'd0,     STAT_DONE),
    chk_row(CMD_FREE,    64'd5,     64'd5,     STAT_IGN),
    chk_row(CMD_DECL,    ID_NEG1,   ID_NEG1,   STAT_IGN),
    chk_row(CMD_DECL,    64'd1023,  64'd1023,  STAT_DONE),
    chk_row(CMD_DECL,    64'd1023,  64'd1023,  STAT_DONE),
    chk_row(CMD_DECL,    64'd1024,  64'd1024,  STAT_IGN),
    chk_row(CMD_FREE,    64'd1023,  64'd1023,  STAT_DONE),
    chk_row(CMD_DECL,    64'd1023,  64'd1023,  STAT_DONE),
    chk_row(CMD_UNKNOWN, ID_BOTTOM, ID_BOTTOM, STAT_IGN),
    chk_row(CMD_FREE,    ID_TOP,    ID_TOP,    STAT_IGN),
    req_row(CMD_GEN,     64'd0),
    // Reversed bounds give the pool 3..5 with the invalid ID 4 inside.
    reg_row(REG_MIN,     64'd5),
    reg_row(REG_MAX,     64'd3),
    reg_row(REG_INV,     64'd4),
    chk_row(CMD_GEN,     64'd0,     64'd3,     STAT_DONE),
    chk_row(CMD_GEN,     64'd0,     64'd5,     STAT_DONE),
    chk_row(CMD_GEN,     64'd0,     64'd4,     STAT_EXH),
    chk_row(CMD_DECL,    64'd4,     64'd4,     STAT_IGN),
    chk_row(CMD_FREE,    64'd3,     64'd3,     STAT_DONE),
    req_row(CMD_GEN,     64'd0),
    // The spare index must leave the pool as it is, still exhausted.
    reg_row(REG_SPARE,   64'd1234),
    req_row(CMD_GEN,     64'd0),
    // Equal bounds at the very top pull the low end down by one.
    reg_row(REG_MIN,     ID_TOP),
    reg_row(REG_MAX,     ID_TOP),
    chk_row(CMD_GEN,     64'd0,     ID_TOP - 64'd1, STAT_DONE),
    chk_row(CMD_GEN,     64'd0,     ID_TOP,         STAT_DONE),
    chk_row(CMD_GEN,     64'd0,     64'd4,          STAT_EXH)
  };

  // --------------------------------------------------------------------------
  // Channel drivers. Everything is driven with nonblocking assignments just
  // after a rising edge, and handshakes are sampled at the edge itself.
  // --------------------------------------------------------------------------

  // Sends one request. Valid is only lowered when the sender chooses to idle;
  // otherwise the next request follows straight on in the same step as the
  // last transfer, so valid never drops and rises within one step.
  task automatic send_request(in_item_t req, bit typed, out_item_t want);
    out_item_t pred;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    pred = predict_pool_result(req);
    pending_results.push_back(typed ? want : pred);
    // IDs known to be in use feed the well-formed frees of the random part.
    if (pred.status == STAT_DONE && (req.cmd == CMD_GEN || req.cmd == CMD_DECL))
      held_ids.push_back(pred.result_id);
  endtask

  // Lowers the request valid and waits until every result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    write_pool_reg(idx, val);
    held_ids.delete();
  endtask

  // Random request mix: mostly generates and well-formed frees and declares
  // within the pool, some IDs just outside it or equal to the invalid ID, and
  // a share of raw noise with any command and any 64-bit ID.
  function automatic in_item_t next_request();
    in_item_t req;
    int       pick, k;
    pick    = $urandom_range(99);
    req.cmd = CMD_GEN;
    req.id  = {$urandom, $urandom};
    if (pick >= 45 && pick < 65 && held_ids.size() > 0) begin
      k       = $urandom_range(held_ids.size() - 1);
      req.cmd = CMD_FREE;
      req.id  = held_ids[k];
      held_ids.delete(k);
    end else if (pick >= 65 && pick < 77) begin
      req.cmd = CMD_DECL;
      req.id  = id_at(64'($urandom_range(pool_span)));
    end else if (pick >= 77 && pick < 85) begin
      req.cmd = CMD_FREE;
      req.id  = id_at(64'($urandom_range(pool_span)));
    end else if (pick >= 85 && pick < 90) begin
      req.cmd = $urandom_range(1) ? CMD_DECL : CMD_FREE;
      case ($urandom_range(2))
        0:       req.id = id_at('1);
        1:       req.id = id_at(64'(pool_span + 1));
        default: req.id = reg_inv;
      endcase
    end else if (pick >= 90) begin
      req.cmd = 2'($urandom_range(3));
    end
    return req;
  endfunction

  // The receiver stalls at random with the current probability.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Every result transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_id %0d status %0d",
               out_data.result_id, out_data.status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_id !== want.result_id) begin
          $error("result_id mismatch: expected %0d, got %0d",
                 want.result_id, out_data.result_id);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    in_item_t        req;
    out_item_t       want;
    logic [ID_W-1:0] lo;
    reg_lo  = '0;
    reg_hi  = 64'd1023;
    reg_inv = '1;
    rebuild_pool();
    send_idle = 35;
    recv_idle = 68;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_tbl[i]) begin
      if (directed_tbl[i].kind == ROW_REG) begin
        write_reg(directed_tbl[i].code, directed_tbl[i].val);
      end else begin
        req.cmd        = directed_tbl[i].code;
        req.id         = directed_tbl[i].val;
        want.result_id = directed_tbl[i].want_id;
        want.status    = directed_tbl[i].want_st;
        send_request(req, directed_tbl[i].kind == ROW_CHK, want);
      end
    end

    // Each random phase sets all three registers, then streams requests.
    // The idling pattern swaps at phase 3 and stops for the last two phases.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_idle = 68;
        recv_idle = 35;
      end
      if (p == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p == 6) begin
        lo = {$urandom, $urandom};
        write_reg(REG_MIN, lo);
        write_reg(REG_MAX, lo + $urandom_range(40));
        write_reg(REG_INV, lo + $urandom_range(44));
      end else begin
        write_reg(REG_MIN, PHASE_CFG[p][0]);
        write_reg(REG_MAX, PHASE_CFG[p][1]);
        write_reg(REG_INV, PHASE_CFG[p][2]);
      end
      repeat (PHASE_REQS) send_request(next_request(), 1'b0, '0);
    end

    // Let everything come back, then watch a while for stray results.
    drain_results();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
